FILE: rtl/brsb_pkg.sv
package brsb_pkg;

  // Packed stream widths, whole bytes
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 80;

  // Field widths fixed by the interface
  localparam int FLAG_W = 1;
  localparam int ID_W   = 5;
  localparam int MODE_W = 3;
  localparam int WORD_W = 32;

  // Tags are widened to this before trimming to the configured tag width
  localparam int TAG_EXT_W = 8;

  // Sequential step when the branch falls through
  localparam logic [WORD_W-1:0] PC_STEP = 32'd4;

  // Branch compare codes
  typedef enum logic [MODE_W-1:0] {
    CMP_EQ  = 3'd0,
    CMP_NE  = 3'd1,
    CMP_LT  = 3'd2,
    CMP_GE  = 3'd3,
    CMP_LTU = 3'd4,
    CMP_GEU = 3'd5
  } cmp_mode_t;

endpackage

FILE: rtl/branch_resolve_slot_buffer_core.sv
// Branch resolve slot buffer. Each input item is one tick of the core: an
// optional squash, an optional result broadcast and an optional candidate
// branch. The block keeps up to SLOT_COUNT resolved branches, each with its
// reorder tag, branch PC and next PC, and returns exactly one result item
// per input item: accept decision, empty/full flags and the oldest (lowest
// tag) slot, all as seen before that tick. Each item passes the input
// register, then the result register, and one item is taken every cycle;
// the rate only drops when the result side stalls. Head selection is a parallel
// all-pairs tag compare, so a tick is resolved in a single pass.
module branch_resolve_slot_buffer_core #(
  parameter int SLOT_COUNT = 8,
  parameter int TAG_BITS   = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata, from bit 0: squash_valid, squash_tag[5], bcast_valid,
  // bcast_tag[5], br_valid, br_tag[5], mode[3], lhs_value[32],
  // rhs_value[32], branch_pc[32], offset[32], cand_slot_id[5], zero pad
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [brsb_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata, from bit 0: accepted, accept_id[5], unit_empty, unit_full,
  // head_valid, head_tag[5], head_pc_from[32], head_pc_next[32], zero pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [brsb_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int WW = brsb_pkg::WORD_W;
  localparam int EW = brsb_pkg::TAG_EXT_W;

  // Pipeline registers
  logic                           in_v_r;
  logic [brsb_pkg::IN_DATA_W-1:0] in_data_r;
  logic                           out_v_r;
  logic [brsb_pkg::OUT_DATA_W-1:0] out_data_r;

  // Slot state
  logic [SLOT_COUNT-1:0] live_r;
  logic [SLOT_COUNT-1:0] live_nxt;
  logic [TAG_BITS-1:0]   tag_r     [SLOT_COUNT];
  logic [WW-1:0]         from_pc_r [SLOT_COUNT];
  logic [WW-1:0]         next_pc_r [SLOT_COUNT];

  logic out_free;
  logic advance;

  // Decoded fields of the registered item
  logic                sq_v, bc_v, c_v;
  logic [TAG_BITS-1:0] sq_t, bc_t, c_t;
  logic [EW-1:0]       sq_t_ext, bc_t_ext, c_t_ext;
  logic [brsb_pkg::MODE_W-1:0] mode_f;
  logic [WW-1:0]       lhs, rhs, pc, off;
  logic [brsb_pkg::ID_W-1:0]   cid;

  logic [SLOT_COUNT-1:0] head_sel;
  logic [SLOT_COUNT-1:0] free_oh;
  logic [SLOT_COUNT-1:0] sq_kill;
  logic [SLOT_COUNT-1:0] bc_match;
  logic [SLOT_COUNT-1:0] bc_oh;
  logic                  bc_en;
  logic                  empty, full, accept, taken;
  logic [TAG_BITS-1:0]   head_tag;
  logic [EW-1:0]         head_tag_ext;
  logic [WW-1:0]         head_from, head_next, new_next_pc;
  logic [brsb_pkg::OUT_DATA_W-1:0] out_data_nxt;

  // Handshake: the result register frees the input register
  assign out_free   = !out_v_r || out_tready;
  assign advance    = in_v_r && out_free;
  assign in_tready  = !in_v_r || out_free;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // Field unpacking
  assign sq_v     = in_data_r[0];
  assign sq_t_ext = EW'(in_data_r[5:1]);
  assign bc_v     = in_data_r[6];
  assign bc_t_ext = EW'(in_data_r[11:7]);
  assign c_v      = in_data_r[12];
  assign c_t_ext  = EW'(in_data_r[17:13]);
  assign mode_f   = in_data_r[20:18];
  assign lhs      = in_data_r[52:21];
  assign rhs      = in_data_r[84:53];
  assign pc       = in_data_r[116:85];
  assign off      = in_data_r[148:117];
  assign cid      = in_data_r[153:149];
  assign sq_t     = sq_t_ext[TAG_BITS-1:0];
  assign bc_t     = bc_t_ext[TAG_BITS-1:0];
  assign c_t      = c_t_ext[TAG_BITS-1:0];

  // Head slot: lowest tag, lowest index on ties
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      head_sel[i] = live_r[i];
      for (int j = 0; j < SLOT_COUNT; j++) begin
        if (j < i) begin
          if (live_r[j] && !(tag_r[i] < tag_r[j])) head_sel[i] = 1'b0;
        end else if (j > i) begin
          if (live_r[j] && !(tag_r[i] <= tag_r[j])) head_sel[i] = 1'b0;
        end
      end
    end
  end

  // One-hot read of the head slot; zero when no slot is live
  always_comb begin
    head_tag  = '0;
    head_from = '0;
    head_next = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (head_sel[i]) begin
        head_tag  = head_tag | tag_r[i];
        head_from = head_from | from_pc_r[i];
        head_next = head_next | next_pc_r[i];
      end
    end
  end
  assign head_tag_ext = EW'(head_tag);

  // Occupancy, lowest free slot
  assign empty   = (live_r == '0);
  assign full    = &live_r;
  assign free_oh = ~live_r & (live_r + SLOT_COUNT'(1));

  // Squash and broadcast removal
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      sq_kill[i]  = sq_v && live_r[i] && (tag_r[i] > sq_t);
      bc_match[i] = live_r[i] && (tag_r[i] == bc_t);
    end
  end
  assign bc_en = bc_v && (!sq_v || (bc_t < sq_t));
  assign bc_oh = bc_match & (~bc_match + SLOT_COUNT'(1));

  assign accept = c_v && !full && !(sq_v && (c_t >= sq_t));

  // Branch compare and target
  always_comb begin
    case (brsb_pkg::cmp_mode_t'(mode_f))
      brsb_pkg::CMP_EQ:  taken = (lhs == rhs);
      brsb_pkg::CMP_NE:  taken = (lhs != rhs);
      brsb_pkg::CMP_LT:  taken = ($signed(lhs) < $signed(rhs));
      brsb_pkg::CMP_GE:  taken = ($signed(lhs) >= $signed(rhs));
      brsb_pkg::CMP_LTU: taken = (lhs < rhs);
      brsb_pkg::CMP_GEU: taken = (lhs >= rhs);
      default:           taken = 1'b0;
    endcase
  end
  assign new_next_pc = taken ? (pc + off) : (pc + brsb_pkg::PC_STEP);

  // Next live vector
  assign live_nxt = (live_r & ~sq_kill & ~(bc_en ? bc_oh : '0))
                  | (accept ? free_oh : '0);

  // Result item
  assign out_data_nxt = {2'b00, head_next, head_from, head_tag_ext[4:0], !empty,
                         full, empty, (accept ? cid : 5'd0), accept};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      live_r  <= '0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (out_free) out_v_r <= in_v_r;
      if (advance) live_r <= live_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_data_r <= in_tdata;
    if (advance) out_data_r <= out_data_nxt;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (advance && accept && free_oh[i]) begin
        tag_r[i]     <= c_t;
        from_pc_r[i] <= pc;
        next_pc_r[i] <= new_next_pc;
      end
    end
  end

endmodule

FILE: rtl/brsb_checker.sv
module brsb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [brsb_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [brsb_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // Input side keeps flowing whenever the result side can take an item
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled although result side is free");

  // Head is present exactly when the unit is not empty, and zero otherwise
  a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8] == !out_tdata[6]) &&
                   (out_tdata[8] || (out_tdata[77:9] == '0)))
    else $error("head fields disagree with empty flag");

  // A full unit never accepts, and a refused candidate echoes no id
  a_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[0] || !out_tdata[7]) &&
                   (out_tdata[0] || (out_tdata[5:1] == 5'd0)))
    else $error("accept decision inconsistent");

endmodule

bind branch_resolve_slot_buffer_core brsb_checker u_brsb_checker (.*);

FILE: verif/branch_resolve_slot_buffer_core_test.sv
`timescale 1ns / 100ps

module branch_resolve_slot_buffer_core_test;

  localparam int SLOT_CNT       = 8;
  localparam int RAND_ITEMS     = 1400;
  localparam int CALM_ITEMS     = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;

  // Compare codes that the block never takes
  localparam logic [brsb_pkg::MODE_W-1:0] CMP_RSVD6 = 3'd6;
  localparam logic [brsb_pkg::MODE_W-1:0] CMP_RSVD7 = 3'd7;

  typedef struct packed {
    logic        sq_v;
    logic [4:0]  sq_tag;
    logic        bc_v;
    logic [4:0]  bc_tag;
    logic        cand_v;
    logic [4:0]  br_tag;
    logic [2:0]  mode;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] pc;
    logic [31:0] offset;
    logic [4:0]  cand_id;
  } tick_in_t;

  typedef struct packed {
    logic        accepted;
    logic [4:0]  accept_id;
    logic        empty;
    logic        full;
    logic        head_v;
    logic [4:0]  head_tag;
    logic [31:0] head_from;
    logic [31:0] head_next;
  } tick_res_t;

  // One tick to send; a fixed status is used instead of the predicted one when set
  typedef struct {
    tick_in_t  stim;
    bit        fixed;
    tick_res_t status;
  } tick_job_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [brsb_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [brsb_pkg::OUT_DATA_W-1:0] out_tdata;

  // Shadow of the slot buffer
  logic [SLOT_CNT-1:0] slot_busy = '0;
  logic [4:0]          held_tag  [SLOT_CNT];
  logic [31:0]         held_pc   [SLOT_CNT];
  logic [31:0]         held_next [SLOT_CNT];

  tick_job_t pending_ticks[$];
  tick_res_t expected_status[$];
  int        mismatches = 0;
  int        quiet_cycles = 0;

  // Receiver stall knobs; the stimulus process sets stall_pct and calm
  int stall_pct = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  branch_resolve_slot_buffer_core #(
    .SLOT_COUNT(SLOT_CNT),
    .TAG_BITS  (5)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tick_in_t mk(int sq_v, int sq_tag, int bc_v, int bc_tag, int cand_v,
                                  int br_tag, int mode, int lhs, int rhs, int pc,
                                  int offset, int cand_id);
    tick_in_t t;
    t = '{1'(sq_v), 5'(sq_tag), 1'(bc_v), 5'(bc_tag), 1'(cand_v), 5'(br_tag), 3'(mode),
          32'(lhs), 32'(rhs), 32'(pc), 32'(offset), 5'(cand_id)};
    return t;
  endfunction

  // Status of one tick, then the slot buffer update
  function automatic tick_res_t resolve_tick(tick_in_t t);
    tick_res_t           r;
    int                  head_idx;
    int                  free_idx;
    bit                  taken;
    bit                  freed;
    logic [SLOT_CNT-1:0] busy_next;
    r = '0;
    head_idx = -1;
    free_idx = -1;
    freed = 1'b0;
    taken = 1'b0;
    for (int i = 0; i < SLOT_CNT; i++) begin
      if (slot_busy[i]) begin
        if (head_idx < 0 || held_tag[i] < held_tag[head_idx]) head_idx = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    r.empty = (slot_busy == '0);
    r.full = (slot_busy == '1);
    r.accepted = t.cand_v && !r.full && !(t.sq_v && t.br_tag >= t.sq_tag);
    r.accept_id = r.accepted ? t.cand_id : 5'd0;
    if (head_idx >= 0) begin
      r.head_v = 1'b1;
      r.head_tag = held_tag[head_idx];
      r.head_from = held_pc[head_idx];
      r.head_next = held_next[head_idx];
    end
    busy_next = slot_busy;
    // squash drops every younger slot
    if (t.sq_v) begin
      for (int i = 0; i < SLOT_CNT; i++)
        if (slot_busy[i] && held_tag[i] > t.sq_tag) busy_next[i] = 1'b0;
    end
    // broadcast frees the first match, only if older than the squash
    if (t.bc_v && (!t.sq_v || t.bc_tag < t.sq_tag)) begin
      for (int i = 0; i < SLOT_CNT; i++) begin
        if (!freed && slot_busy[i] && held_tag[i] == t.bc_tag) begin
          busy_next[i] = 1'b0;
          freed = 1'b1;
        end
      end
    end
    if (r.accepted) begin
      case (t.mode)
        brsb_pkg::CMP_EQ:  taken = (t.lhs == t.rhs);
        brsb_pkg::CMP_NE:  taken = (t.lhs != t.rhs);
        brsb_pkg::CMP_LT:  taken = ($signed(t.lhs) < $signed(t.rhs));
        brsb_pkg::CMP_GE:  taken = ($signed(t.lhs) >= $signed(t.rhs));
        brsb_pkg::CMP_LTU: taken = (t.lhs < t.rhs);
        brsb_pkg::CMP_GEU: taken = (t.lhs >= t.rhs);
        default:           taken = 1'b0;
      endcase
      busy_next[free_idx] = 1'b1;
      held_tag[free_idx] = t.br_tag;
      held_pc[free_idx] = t.pc;
      held_next[free_idx] = taken ? t.pc + t.offset : t.pc + brsb_pkg::PC_STEP;
    end
    slot_busy = busy_next;
    return r;
  endfunction

  // Random tick; broadcasts mostly hit a live tag
  function automatic tick_in_t rand_tick();
    tick_in_t t;
    int       pick;
    t.sq_v = ($urandom_range(0, 11) == 0);
    t.sq_tag = 5'($urandom_range(0, 31));
    t.bc_v = ($urandom_range(0, 99) < 70);
    t.bc_tag = 5'($urandom_range(0, 31));
    if (slot_busy != '0 && $urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, SLOT_CNT - 1);
      while (!slot_busy[pick]) pick = (pick + 1) % SLOT_CNT;
      t.bc_tag = held_tag[pick];
    end
    t.cand_v = ($urandom_range(0, 99) < 70);
    t.br_tag = 5'($urandom_range(0, 31));
    if (t.sq_v && $urandom_range(0, 3) == 0) t.br_tag = t.sq_tag;
    t.mode = 3'($urandom_range(0, 7));
    t.lhs = $urandom;
    case ($urandom_range(0, 3))
      0:       t.rhs = t.lhs;
      1:       t.rhs = t.lhs ^ 32'h8000_0000;
      default: t.rhs = $urandom;
    endcase
    t.pc = $urandom;
    t.offset = $urandom;
    t.cand_id = 5'($urandom_range(0, 31));
    return t;
  endfunction

  task automatic send_tick(tick_job_t job);
    tick_in_t t;
    t = job.stim;
    pending_ticks.push_back(job);
    in_tdata <= {6'b0, t.cand_id, t.offset, t.pc, t.rhs, t.lhs, t.mode, t.br_tag,
                 t.cand_v, t.bc_tag, t.bc_v, t.sq_tag, t.sq_v};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic maybe_idle(int pct);
    if ($urandom_range(0, 99) < pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Hold off until every expected status item is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_ticks.size() != 0 || expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Accepted input item: predict its status
  always @(posedge clk) begin : in_mon
    tick_job_t job;
    tick_res_t r;
    if (rst_n && in_tvalid && in_tready && pending_ticks.size() != 0) begin
      job = pending_ticks.pop_front();
      r = resolve_tick(job.stim);
      expected_status.push_back(job.fixed ? job.status : r);
    end
  end

  // Accepted result item: compare with the oldest expectation
  always @(posedge clk) begin : out_mon
    tick_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_status.size() == 0) begin
        $error("result item with nothing expected: %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(out_tdata[0]));
        check_field("accept_id", 32'(want.accept_id), 32'(out_tdata[5:1]));
        check_field("unit_empty", 32'(want.empty), 32'(out_tdata[6]));
        check_field("unit_full", 32'(want.full), 32'(out_tdata[7]));
        check_field("head_valid", 32'(want.head_v), 32'(out_tdata[8]));
        check_field("head_tag", 32'(want.head_tag), 32'(out_tdata[13:9]));
        check_field("head_pc_from", want.head_from, out_tdata[45:14]);
        check_field("head_pc_next", want.head_next, out_tdata[77:46]);
      end
    end
  end

  // Result side stalls in bursts
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("branch_resolve_slot_buffer_core_test NOT OK");
      $finish;
    end
  end

  initial begin : stim
    tick_job_t dir_tab[$];
    int        idle_pct;
    idle_pct = 20;
    stall_pct <= 20;

    // empty unit after reset
    dir_tab.push_back('{mk(0, 0, 0, 0, 0, 0, brsb_pkg::CMP_EQ, 0, 0, 0, 0, 0), 1'b1,
                        '{1'b0, 5'd0, 1'b1, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0}});
    dir_tab.push_back('{mk(0, 0, 0, 0, 1, 10, brsb_pkg::CMP_EQ, 32'h1234_5678,
                           32'h1234_5678, 32'h1000, 32'h20, 31), 1'b1,
                        '{1'b1, 5'd31, 1'b1, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0}});
    // every compare, PC wrap, signed extremes, duplicate tags
    dir_tab.push_back('{mk(0, 0, 0, 0, 1, 3, brsb_pkg::CMP_NE, 0, 0, 32'hFFFF_FFFC,
                           32'h40, 1), 1'b0, '0});
    dir_tab.push_back('{mk(0, 0, 0, 0, 1, 31, brsb_pkg::CMP_LT, 32'h8000_0000,
                           32'h7FFF_FFFF, 0, 32'h8000_0000, 2), 1'b0, '0});
    dir_tab.push_back('{mk(0, 0, 0, 0, 1, 0, brsb_pkg::CMP_GE, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 3), 1'b0, '0});
    dir_tab.push_back('{mk(0, 0, 0, 0, 1, 20, brsb_pkg::CMP_LTU, 0, 32'hFFFF_FFFF,
                           32'h100, 32'hFFFF_FFF0, 4), 1'b0, '0});
    dir_tab.push_back('{mk(0, 0, 0, 0, 1, 20, brsb_pkg::CMP_GEU, 0, 32'hFFFF_FFFF,
                           32'h200, 32'h10, 5), 1'b0, '0});
    dir_tab.push_back('{mk(0, 0, 0, 0, 1, 15, CMP_RSVD6, 5, 5, 32'h300, 32'h10, 6),
                        1'b0, '0});
    dir_tab.push_back('{mk(0, 0, 0, 0, 1, 15, CMP_RSVD7, 5, 5, 32'h400, 32'h10, 7),
                        1'b0, '0});
    // full unit refuses even though a duplicate tag frees a slot
    dir_tab.push_back('{mk(0, 0, 1, 20, 1, 1, brsb_pkg::CMP_EQ, 0, 0, 32'h500, 32'h8, 8),
                        1'b1,
                        '{1'b0, 5'd0, 1'b0, 1'b1, 1'b1, 5'd0, 32'hFFFF_FFFF,
                          32'h7FFF_FFFE}});
    // squashed candidate, broadcast with no match
    dir_tab.push_back('{mk(1, 25, 1, 7, 1, 25, brsb_pkg::CMP_EQ, 1, 1, 32'h600, 32'h8, 9),
                        1'b0, '0});
    // broadcast blocked by an older squash
    dir_tab.push_back('{mk(1, 12, 1, 15, 1, 11, brsb_pkg::CMP_LTU, 1, 2, 32'h700,
                           32'hFFFF_FF00, 10), 1'b0, '0});
    dir_tab.push_back('{mk(0, 0, 1, 0, 1, 5, brsb_pkg::CMP_GEU, 2, 2, 32'h800,
                           32'hFFFF_FFFC, 11), 1'b0, '0});
    // squash to tag zero empties the unit
    dir_tab.push_back('{mk(1, 0, 0, 0, 0, 0, brsb_pkg::CMP_EQ, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{mk(1, 31, 0, 0, 1, 30, brsb_pkg::CMP_NE, 32'hFFFF_FFFF, 0,
                           32'hFFFF_FFF8, 32'h8, 17), 1'b1,
                        '{1'b1, 5'd17, 1'b1, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0}});
    // broadcast tag equal to squash tag is ignored; idle candidate id not echoed
    dir_tab.push_back('{mk(1, 30, 1, 30, 0, 0, brsb_pkg::CMP_EQ, 0, 0, 0, 0, 21), 1'b0,
                        '0});
    dir_tab.push_back('{mk(0, 0, 1, 30, 0, 0, brsb_pkg::CMP_EQ, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{mk(1, 31, 0, 0, 1, 31, brsb_pkg::CMP_GEU, 0, 0, 32'h900, 32'h8, 12),
                        1'b1,
                        '{1'b0, 5'd0, 1'b1, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0}});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_tab[i]) begin
      maybe_idle(idle_pct);
      send_tick(dir_tab[i]);
    end
    wait_drained();

    // random ticks
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - CALM_ITEMS) begin
        idle_pct = 0;
        calm <= 1'b1;
      end else if (n < RAND_ITEMS - CALM_ITEMS && n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct <= 0;
          1:       stall_pct <= 15;
          default: stall_pct <= 40;
        endcase
      end
      if (n == RAND_ITEMS / 2) wait_drained();
      maybe_idle(idle_pct);
      send_tick('{rand_tick(), 1'b0, '0});
    end

    in_tvalid <= 1'b0;
    while (pending_ticks.size() != 0 || expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("branch_resolve_slot_buffer_core_test OK");
    else
      $display("branch_resolve_slot_buffer_core_test NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/brsb_pkg.sv
rtl/branch_resolve_slot_buffer_core.sv
rtl/brsb_checker.sv
verif/branch_resolve_slot_buffer_core_test.sv
